@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the prime tester core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/tdp_pkg.sv @@
// Shared types and codes for the trial division prime tester
package tdp_pkg;
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LEARN = 2'd0;
    localparam t_kind KIND_TEST  = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;
    localparam t_kind KIND_SKIP  = 2'd3;
    localparam int CAND_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SIZE_W  = 11;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 48;
endpackage

@@ hw/rtl/trial_division_prime_tester_core.sv @@
// Trial division prime tester: top level with table RAM, divider and sequencer
// Usage: send words on the s_axis channel, tdata = candidate[31:0] and
// tuser = kind[1:0]. Kind 0 tests and learns a prime into the table, kind 1
// tests and counts, kind 2 clears the count, kind 3 leaves the state unchanged.
// One result word per input word leaves on m_axis, tdata = {table_entries,
// prime_count, table_full, table_exhausted, prime_flag} from the top down, padded to 48.
// A clear or kind 3 word goes from the input registers straight to the result
// state. A test or learn walks the table: each entry is read from RAM, loaded
// as divisor and run through the bit-serial remainder unit, until an entry
// divides the candidate, an entry's square passes the candidate, or the table
// runs out; the result is then registered.
// The divider loop sets the rate; one item is in flight at a time, and the next
// word can be accepted in the cycle after the result is registered.
// Reset (i_rst_n low, synchronous) leaves the table empty and the count zero.
// Entries at or above the fill count are never read, so no clearing pass runs.
// When the receiver stalls, the result holds in the output register; the next
// item is accepted and worked while that result waits, and finishes only when
// the output register has drained. Input stalls until then.
module trial_division_prime_tester_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PRIME_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [tdp_pkg::IN_W-1:0] s_axis_tdata,  // candidate[31:0]
    input  tdp_pkg::t_kind           s_axis_tuser,  // kind[1:0]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // prime_flag, table_exhausted, table_full, prime_count[34:3], table_entries[45:35]
    output logic [tdp_pkg::OUT_W-1:0] m_axis_tdata
);
    import tdp_pkg::*;
    `include "assert_macros.svh"

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int TS_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        r_state;
    t_kind             r_kind;
    logic [CAND_W-1:0] r_cand;
    logic [TS_W-1:0]   r_size;
    logic [TS_W-1:0]   r_idx;
    logic [COUNT_W-1:0] r_count;
    logic              r_prime, r_exh;
    logic              r_in_busy;
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;
    logic [PRIME_WIDTH-1:0] r_d;
    logic              r_div_start;

    logic [PRIME_WIDTH-1:0] w_rdata;
    logic              w_we;
    logic              w_div_done, w_zero_rem;
    logic [2*PRIME_WIDTH-1:0] w_sq;
    logic              w_sq_big;
    logic              w_fits;

    assign s_axis_tready = !r_in_busy;

    tdp_ram #(.WIDTH(PRIME_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_size[AW-1:0]),
        .i_wdata(r_cand[PRIME_WIDTH-1:0]),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    tdp_divider #(.DIV_W(PRIME_WIDTH)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_dividend(r_cand),
        .i_divisor (r_d),
        .o_done    (w_div_done),
        .o_zero_rem(w_zero_rem)
    );

    assign w_sq = r_d * r_d;
    generate
        if (2 * PRIME_WIDTH > CAND_W) begin : g_wide
            assign w_sq_big = w_sq > (2*PRIME_WIDTH)'(r_cand);
        end else begin : g_narrow
            assign w_sq_big = CAND_W'(w_sq) > r_cand;
        end
        if (PRIME_WIDTH >= CAND_W) begin : g_fit_all
            assign w_fits = 1'b1;
        end else begin : g_fit
            assign w_fits = (r_cand[CAND_W-1:PRIME_WIDTH] == '0);
        end
    endgenerate

    assign w_we = (r_state == ST_FIN) && !r_ovalid && (r_kind == KIND_LEARN) && r_prime
                  && (r_size < TS_W'(TABLE_DEPTH)) && w_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= TS_W'(1);
            r_count     <= '0;
            r_in_busy   <= 1'b0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == ST_CHK);
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && !r_in_busy) begin
                        r_kind    <= s_axis_tuser;
                        r_cand    <= s_axis_tdata;
                        r_in_busy <= 1'b1;
                        r_idx     <= TS_W'(1);
                        r_prime   <= 1'b0;
                        r_exh     <= 1'b0;
                        if (s_axis_tuser == KIND_LEARN || s_axis_tuser == KIND_TEST) begin
                            r_state <= ST_READ;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_READ: begin
                    if (r_idx >= r_size) begin
                        r_prime <= 1'b1;
                        r_exh   <= 1'b1;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_d     <= w_rdata;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // square bound checked while the remainder runs; skip the load cycle
                    if (!r_div_start) begin
                        if (w_sq_big) begin
                            r_prime <= 1'b1;
                            r_state <= ST_FIN;
                        end else if (w_div_done) begin
                            if (r_d != '0 && w_zero_rem) begin
                                r_prime <= 1'b0;
                                r_state <= ST_FIN;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid) begin
                        logic             v_full;
                        logic [TS_W-1:0]  v_size;
                        logic [COUNT_W-1:0] v_count;
                        v_full  = 1'b0;
                        v_size  = r_size;
                        v_count = r_count;
                        if (r_kind == KIND_LEARN && r_prime) begin
                            if (w_we) v_size = r_size + 1'b1;
                            else      v_full = 1'b1;
                        end else if (r_kind == KIND_TEST && r_prime && !(&r_count)) begin
                            v_count = r_count + 1'b1;
                        end else if (r_kind == KIND_CLEAR) begin
                            v_count = '0;
                        end
                        r_size    <= v_size;
                        r_count   <= v_count;
                        r_ovalid  <= 1'b1;
                        r_odata   <= OUT_W'({ (SIZE_W)'(v_size), v_count, v_full,
                                              r_exh, r_prime });
                        r_in_busy <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `ASSERT_IMPL(a_busy_idle, i_clk, i_rst_n, (r_state == ST_IDLE) || r_in_busy, "idle walk")
    `ASSERT_IMPL(a_size_rng, i_clk, i_rst_n, r_size != '0 && r_size <= TS_W'(TABLE_DEPTH), "size")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !m_axis_tready,
                 r_ovalid && $stable(r_odata), "result lost")
endmodule

@@ hw/rtl/tdp_ram.sv @@
// Generic single-port write, single-port read RAM with registered read data
module tdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/tdp_divider.sv @@
// Radix-2 restoring remainder unit, one quotient bit per cycle
module tdp_divider #(
    parameter int DIV_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [tdp_pkg::CAND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]         i_divisor,
    output logic                     o_done,
    output logic                     o_zero_rem
);
    import tdp_pkg::*;

    localparam int CNT_W = $clog2(CAND_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [CAND_W-1:0] r_quo;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_div;
    logic             r_done;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;

    assign w_shift = {r_rem[DIV_W-1:0], r_quo[CAND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CAND_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[CAND_W-2:0], 1'b0};
                r_rem <= w_diff[DIV_W] ? w_shift : w_diff;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_zero_rem = (r_rem == '0);
endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the trial division prime tester core
module tb;
    import tdp_pkg::*;

    localparam int DEPTH   = 1024;
    localparam int ENTRY_W = 16;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] cand;
    } t_word_in;

    typedef struct packed {
        logic        prime_flag;
        logic        exhausted;
        logic        full;
        logic [31:0] count;
        logic [10:0] entries;
    } t_verdict;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // candidate[31:0]
    t_kind             s_axis_tuser;   // kind[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // prime_flag, exhausted, full, count[34:3], entries[45:35]

    trial_division_prime_tester_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // shadow of the block's state; entry zero is never read
    logic [ENTRY_W-1:0] prime_tbl [DEPTH];
    int unsigned        tbl_size = 1;
    logic [31:0]        found_cnt = '0;

    t_word_in    pending_words[$];
    t_verdict    expected_verdicts[$];
    int unsigned errors;
    int unsigned words_sent;
    int unsigned words_queued;

    function automatic t_verdict judge_word(t_word_in w);
        t_verdict    v;
        int unsigned i;
        logic [63:0] d;
        logic        done;
        v = '0;
        if (w.kind == KIND_LEARN || w.kind == KIND_TEST) begin
            i = 1;
            done = 1'b0;
            while (!done) begin
                if (i >= tbl_size || i >= DEPTH) begin
                    v.exhausted = 1'b1;
                    v.prime_flag = 1'b1;
                    done = 1'b1;
                end else begin
                    d = 64'(prime_tbl[i]);
                    if (d * d > 64'(w.cand)) begin
                        v.prime_flag = 1'b1;
                        done = 1'b1;
                    end else if (d != 0 && (w.cand % d[31:0]) == 0) begin
                        done = 1'b1;
                    end
                    i++;
                end
            end
            if (w.kind == KIND_LEARN) begin
                if (v.prime_flag) begin
                    if (tbl_size >= DEPTH || w.cand > 32'((1 << ENTRY_W) - 1))
                        v.full = 1'b1;
                    else begin
                        prime_tbl[tbl_size] = w.cand[ENTRY_W-1:0];
                        tbl_size++;
                    end
                end
            end else if (v.prime_flag && found_cnt != 32'hFFFF_FFFF) begin
                found_cnt++;
            end
        end else if (w.kind == KIND_CLEAR) begin
            found_cnt = '0;
        end
        v.count = found_cnt;
        v.entries = 11'(tbl_size);
        return v;
    endfunction

    // sender
    int unsigned send_gap;
    logic        send_calm;
    t_word_in    cur_word;
    always @(posedge i_clk) begin
        logic     need;
        logic     nv;
        t_word_in nw;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= KIND_LEARN;
            send_gap <= 0;
            send_calm <= 1'b0;
            cur_word = '0;
        end else begin
            need = !s_axis_tvalid;
            nv = s_axis_tvalid;
            nw = cur_word;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_verdicts.push_back(judge_word(cur_word));
                words_sent++;
                need = 1'b1;
                nv = 1'b0;
                if (words_sent % 150 == 0)
                    send_calm <= ~send_calm;
            end
            if (need) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() > 0) begin
                    nw = pending_words.pop_front();
                    nv = 1'b1;
                    send_gap <= send_calm ? 0 : $urandom_range(0, 13);
                end
            end
            cur_word = nw;
            s_axis_tvalid <= nv;
            s_axis_tdata <= nw.cand;
            s_axis_tuser <= nw.kind;
        end
    end

    // long receiver hold-off so the core backs up into its input
    int unsigned hold_cyc;
    logic        hold_off;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cyc <= 0;
            hold_off <= 1'b0;
        end else begin
            hold_cyc <= hold_cyc + 1;
            hold_off <= (hold_cyc >= 30_000) && (hold_cyc < 33_000);
        end
    end

    // receiver
    int unsigned recv_gap;
    int unsigned results_seen;
    logic        recv_calm;
    always @(posedge i_clk) begin
        t_verdict    got;
        t_verdict    want;
        int unsigned g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
            recv_calm <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2],
                       m_axis_tdata[34:3], m_axis_tdata[45:35]};
                results_seen++;
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.prime_flag !== want.prime_flag) begin
                        $display("%0t: prime flag expected %0d actual %0d",
                                 $time, want.prime_flag, got.prime_flag);
                        errors++;
                    end
                    if (got.exhausted !== want.exhausted) begin
                        $display("%0t: table_exhausted expected %0d actual %0d",
                                 $time, want.exhausted, got.exhausted);
                        errors++;
                    end
                    if (got.full !== want.full) begin
                        $display("%0t: table_full expected %0d actual %0d",
                                 $time, want.full, got.full);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: prime_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        errors++;
                    end
                    if (got.entries !== want.entries) begin
                        $display("%0t: table_entries expected %0d actual %0d",
                                 $time, want.entries, got.entries);
                        errors++;
                    end
                end
                if (results_seen % 170 == 0)
                    recv_calm <= ~recv_calm;
                g = recv_calm ? 0 : $urandom_range(0, 13);
                recv_gap <= (g > 0) ? g - 1 : 0;
                m_axis_tready <= (g == 0) && !hold_off;
            end else if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_word(t_kind k, logic [31:0] c);
        t_word_in w;
        w.kind = k;
        w.cand = c;
        pending_words.push_back(w);
        words_queued++;
    endtask

    initial begin
        int unsigned next_odd;
        int unsigned r;
        words_queued = 0;
        i_rst_n = 1'b0;

        queue_word(KIND_TEST, 32'd0);
        queue_word(KIND_TEST, 32'd1);
        queue_word(KIND_TEST, 32'd4);
        queue_word(KIND_LEARN, 32'd3);
        queue_word(KIND_TEST, 32'd4);
        queue_word(KIND_TEST, 32'd8);
        queue_word(KIND_LEARN, 32'd9);
        queue_word(KIND_LEARN, 32'd5);
        queue_word(KIND_LEARN, 32'd7);
        queue_word(KIND_TEST, 32'hFFFF_FFFF);
        queue_word(KIND_TEST, 32'hFFFF_FFFB);
        queue_word(KIND_LEARN, 32'd65537);
        queue_word(KIND_LEARN, 32'hFFFF_FFFB);
        queue_word(KIND_TEST, 32'd25);
        queue_word(KIND_SKIP, 32'hA5A5_5A5A);
        queue_word(KIND_CLEAR, 32'hFFFF_FFFF);
        queue_word(KIND_TEST, 32'd49);
        queue_word(KIND_TEST, 32'd97);
        queue_word(KIND_SKIP, 32'h0000_0001);

        // grow the table with ascending odd numbers, test mostly small values
        next_odd = 11;
        for (int n = 0; n < 300; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                queue_word(KIND_LEARN, next_odd);
                next_odd += 2;
            end else if (r < 38)
                queue_word(KIND_LEARN, $urandom_range(0, 200000));
            else if (r < 43)
                queue_word(KIND_TEST, $urandom);
            else if (r < 48)
                queue_word(KIND_CLEAR, $urandom);
            else if (r < 52)
                queue_word(KIND_SKIP, $urandom);
            else
                queue_word(KIND_TEST, $urandom_range(0, 4095));
        end

        // fill to capacity: values below nine stop at the entry 3
        for (int n = 0; n < 1050; n++)
            queue_word(KIND_LEARN, $urandom_range(0, 8));
        queue_word(KIND_TEST, 32'hFFFF_FFFB);
        queue_word(KIND_TEST, 32'd1_000_003);
        queue_word(KIND_LEARN, 32'd11);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent < words_queued || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (errors == 0)
            $display("trial_division_prime_tester_core verification clean");
        else
            $display("trial_division_prime_tester_core verification failed");
        $finish;
    end

    initial begin
        #240_000_000;
        $display("trial_division_prime_tester_core verification failed");
        $finish;
    end
endmodule
